>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers clocked on clk, with and without reset disable
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked only while out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

>>> rtl/stdr_pkg.sv
// ----------------------------------------------------------------------------
// stdr_pkg
// Shared types and codes of the segment table dma requester
// ----------------------------------------------------------------------------
package stdr_pkg;

  localparam logic [31:0] CHUNK_RESET = 32'h0000_2000;

  // result command codes
  localparam logic [1:0] CMD_COPY   = 2'd0;
  localparam logic [1:0] CMD_DECOMP = 2'd1;
  localparam logic [1:0] CMD_FAULT  = 2'd2;

  // fault codes
  localparam logic [2:0] FLT_NONE      = 3'd0;
  localparam logic [2:0] FLT_NOT_FOUND = 3'd1;
  localparam logic [2:0] FLT_PAST_END  = 3'd2;
  localparam logic [2:0] FLT_NOT_START = 3'd3;
  localparam logic [2:0] FLT_SIZE      = 3'd4;
  localparam logic [2:0] FLT_CHUNKS    = 3'd5;

  // item kinds
  localparam logic KIND_TABLE_WR = 1'b0;
  localparam logic KIND_REQUEST  = 1'b1;

  // configuration register indexes
  localparam logic REG_CHUNK_SIZE  = 1'b0;
  localparam logic REG_ENTRY_COUNT = 1'b1;

  typedef struct packed {
    logic [31:0] vstart;
    logic [31:0] vend;
    logic [31:0] rstart;
    logic [31:0] rend;
  } seg_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_FAULT,
    EMIT_DECOMP,
    EMIT_COPY
  } emit_t;

  // controller to datapath
  typedef struct packed {
    logic       tbl_wr;
    logic       req_load;
    logic       rd_en;
    logic       idx_inc;
    logic       copy_load;
    emit_t      emit;
    logic [2:0] fault_code;
  } stdr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic hit;
    logic compressed;
    logic past_end;
    logic too_many;
    logic not_start;
    logic size_mis;
    logic more;
  } stdr_sts_t;

endpackage

>>> rtl/segment_table_dma_requester.sv
// ----------------------------------------------------------------------------
// segment_table_dma_requester
// Segment table lookup and dma command generation for transfer requests
// ----------------------------------------------------------------------------
// usage:
//   an item is taken when start is high and busy is low. kind 0 writes one
//   table entry and gives no result; busy stays low. kind 1 is a request: the
//   table is scanned from entry zero, each entry by a registered memory read
//   and then a compare. on a hit the checks are made and a fault or decompress
//   result is registered out, or the copy address is loaded and copy commands
//   follow, one copy per cycle up to the one marked last. a miss, once the
//   scan passes entry_count or the table depth, faults as not found.
//   results are one-cycle strobes on out_valid and cannot be held off.
//   busy falls in the cycle the last result is shown, so the next item can
//   be taken at the edge that ends it. the apb port is always ready; write
//   it only while busy is low. reset clears the controller and the registers
//   (chunk_size 0x2000, entry_count 0); the table keeps no reset value.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module segment_table_dma_requester
  import stdr_pkg::*;
#(
  parameter int TABLE_DEPTH = 64,
  parameter int MAX_CHUNKS  = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [5:0]  in_entry_index,
  input  logic [31:0] in_entry_vrom_start,
  input  logic [31:0] in_entry_vrom_end,
  input  logic [31:0] in_entry_rom_start,
  input  logic [31:0] in_entry_rom_end,
  input  logic [31:0] in_req_vrom,
  input  logic [31:0] in_req_ram,
  input  logic [31:0] in_req_size,
  output logic        out_valid,
  output logic [1:0]  out_cmd,
  output logic [31:0] out_rom_addr,
  output logic [31:0] out_ram_addr,
  output logic [31:0] out_length,
  output logic [2:0]  out_fault_code,
  output logic        out_last
);

  logic [31:0] chunk_size_r;
  logic [6:0]  entry_count_r;
  logic        cfg_wr;
  logic        reg_sel;
  stdr_cmd_t   cmd;
  stdr_sts_t   sts;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_size_r  <= CHUNK_RESET;
      entry_count_r <= 7'd0;
    end else if (cfg_wr) begin
      if (reg_sel == REG_CHUNK_SIZE) begin
        chunk_size_r <= pwdata;
      end else begin
        entry_count_r <= pwdata[6:0];
      end
    end
  end

  // unaligned reads return zero
  always_comb begin
    prdata = 32'd0;
    if (paddr[1:0] == 2'b00) begin
      prdata = (reg_sel == REG_ENTRY_COUNT) ? {25'd0, entry_count_r} : chunk_size_r;
    end
  end

  stdr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  stdr_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_CHUNKS  (MAX_CHUNKS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .chunk_size          (chunk_size_r),
    .entry_count         (entry_count_r),
    .in_entry_index      (in_entry_index),
    .in_entry_vrom_start (in_entry_vrom_start),
    .in_entry_vrom_end   (in_entry_vrom_end),
    .in_entry_rom_start  (in_entry_rom_start),
    .in_entry_rom_end    (in_entry_rom_end),
    .in_req_vrom         (in_req_vrom),
    .in_req_ram          (in_req_ram),
    .in_req_size         (in_req_size),
    .out_valid           (out_valid),
    .out_cmd             (out_cmd),
    .out_rom_addr        (out_rom_addr),
    .out_ram_addr        (out_ram_addr),
    .out_length          (out_length),
    .out_fault_code      (out_fault_code),
    .out_last            (out_last)
  );

  `ASSERT_CLK(a_word_while_busy, out_valid |-> $past(busy), "result word outside a request")
  `ASSERT_CLK(a_busy_on_request, $rose(busy) |-> $past(start && in_kind == KIND_REQUEST), "busy without request")
  `ASSERT_CLK(a_not_last_is_copy, (out_valid && !out_last) |-> (out_cmd == CMD_COPY), "non-final word is not a copy")
  `ASSERT_CLK(a_copy_runs_on, (out_valid && !out_last) |=> out_valid, "gap inside a copy burst")
  `ASSERT_CLK(a_fault_clean, (out_valid && out_cmd == CMD_FAULT) |-> (out_last && out_length == 32'd0), "fault word not final or not zero")

endmodule

>>> rtl/stdr_ctrl.sv
// ----------------------------------------------------------------------------
// stdr_ctrl
// Sequencer: table scan, request checks and fault, decompress and copy command emission
// ----------------------------------------------------------------------------
module stdr_ctrl
  import stdr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      in_kind,
  input  stdr_sts_t sts,
  output stdr_cmd_t cmd,
  output logic      busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_EVAL,
    S_COPY
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;
  logic   accept;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.emit       = EMIT_NONE;
    cmd.fault_code = FLT_NONE;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_REQUEST) begin
            cmd.req_load = 1'b1;
            state_nxt    = S_RD;
          end else begin
            cmd.tbl_wr = 1'b1;
          end
        end
      end
      S_RD: begin
        if (sts.scan_done) begin
          cmd.emit       = EMIT_FAULT;
          cmd.fault_code = FLT_NOT_FOUND;
          state_nxt      = S_IDLE;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.hit) begin
          state_nxt = S_EVAL;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_RD;
        end
      end
      S_EVAL: begin
        state_nxt = S_IDLE;
        if (!sts.compressed) begin
          if (sts.past_end) begin
            cmd.emit       = EMIT_FAULT;
            cmd.fault_code = FLT_PAST_END;
          end else if (sts.too_many) begin
            cmd.emit       = EMIT_FAULT;
            cmd.fault_code = FLT_CHUNKS;
          end else begin
            cmd.copy_load = 1'b1;
            state_nxt     = S_COPY;
          end
        end else if (sts.not_start) begin
          cmd.emit       = EMIT_FAULT;
          cmd.fault_code = FLT_NOT_START;
        end else if (sts.size_mis) begin
          cmd.emit       = EMIT_FAULT;
          cmd.fault_code = FLT_SIZE;
        end else begin
          cmd.emit = EMIT_DECOMP;
        end
      end
      S_COPY: begin
        cmd.emit = EMIT_COPY;
        if (!sts.more) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

endmodule

>>> rtl/stdr_dp.sv
// ----------------------------------------------------------------------------
// stdr_dp
// Segment table memory, request registers, checks and result registers
// ----------------------------------------------------------------------------
module stdr_dp
  import stdr_pkg::*;
#(
  parameter int TABLE_DEPTH = 64,
  parameter int MAX_CHUNKS  = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  stdr_cmd_t   cmd,
  output stdr_sts_t   sts,
  input  logic [31:0] chunk_size,
  input  logic [6:0]  entry_count,
  input  logic [5:0]  in_entry_index,
  input  logic [31:0] in_entry_vrom_start,
  input  logic [31:0] in_entry_vrom_end,
  input  logic [31:0] in_entry_rom_start,
  input  logic [31:0] in_entry_rom_end,
  input  logic [31:0] in_req_vrom,
  input  logic [31:0] in_req_ram,
  input  logic [31:0] in_req_size,
  output logic        out_valid,
  output logic [1:0]  out_cmd,
  output logic [31:0] out_rom_addr,
  output logic [31:0] out_ram_addr,
  output logic [31:0] out_length,
  output logic [2:0]  out_fault_code,
  output logic        out_last
);

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int MC_W   = $clog2(MAX_CHUNKS + 1);
  localparam int PROD_W = 32 + MC_W;
  localparam logic [MC_W-1:0] MC = MC_W'(MAX_CHUNKS);

  seg_t mem [TABLE_DEPTH];

  seg_t              ent_r;
  logic [CNT_W-1:0]  idx_r;
  logic [31:0]       vrom_r, ram_r, size_r, rom_r;
  logic [PROD_W-1:0] prod_r;
  logic              wr_ok;
  seg_t              wr_data;
  logic [IDX_W-1:0]  wr_addr;

  logic        out_valid_r, out_last_r;
  logic [1:0]  out_cmd_r;
  logic [31:0] out_rom_r, out_ram_r, out_len_r;
  logic [2:0]  out_code_r;

  assign wr_ok   = (32'(in_entry_index) < 32'(TABLE_DEPTH));
  assign wr_addr = IDX_W'(in_entry_index);
  assign wr_data = '{vstart: in_entry_vrom_start, vend: in_entry_vrom_end,
                     rstart: in_entry_rom_start, rend: in_entry_rom_end};

  always_ff @(posedge clk) begin
    if (cmd.tbl_wr && wr_ok) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      ent_r <= mem[idx_r[IDX_W-1:0]];
    end
  end

  // chunk_size is to change only while idle (the block does not enforce it), so the bound is settled before use
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(chunk_size * MC);
  end

  always_comb begin
    sts.scan_done  = (32'(idx_r) >= 32'(entry_count)) ||
                     (32'(idx_r) >= 32'(TABLE_DEPTH));
    sts.hit        = (vrom_r >= ent_r.vstart) && (vrom_r < ent_r.vend);
    sts.compressed = (ent_r.rend != 32'd0);
    sts.past_end   = ({1'b0, ent_r.vend} < ({1'b0, vrom_r} + {1'b0, size_r}));
    sts.too_many   = (chunk_size != 32'd0) && (PROD_W'(size_r) > prod_r);
    sts.not_start  = (vrom_r != ent_r.vstart);
    sts.size_mis   = (size_r != (ent_r.vend - ent_r.vstart));
    sts.more       = (chunk_size != 32'd0) && (size_r > chunk_size);
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      vrom_r <= in_req_vrom;
      ram_r  <= in_req_ram;
      size_r <= in_req_size;
      idx_r  <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + CNT_W'(1);
    end
    if (cmd.copy_load) begin
      rom_r <= ent_r.rstart + vrom_r - ent_r.vstart;
    end else if (cmd.emit == EMIT_COPY && sts.more) begin
      rom_r  <= rom_r + chunk_size;
      ram_r  <= ram_r + chunk_size;
      size_r <= size_r - chunk_size;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.emit != EMIT_NONE);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.emit)
      EMIT_FAULT: begin
        out_cmd_r  <= CMD_FAULT;
        out_rom_r  <= 32'd0;
        out_ram_r  <= 32'd0;
        out_len_r  <= 32'd0;
        out_code_r <= cmd.fault_code;
        out_last_r <= 1'b1;
      end
      EMIT_DECOMP: begin
        out_cmd_r  <= CMD_DECOMP;
        out_rom_r  <= ent_r.rstart;
        out_ram_r  <= ram_r;
        out_len_r  <= ent_r.rend - ent_r.rstart;
        out_code_r <= FLT_NONE;
        out_last_r <= 1'b1;
      end
      EMIT_COPY: begin
        out_cmd_r  <= CMD_COPY;
        out_rom_r  <= rom_r;
        out_ram_r  <= ram_r;
        out_len_r  <= sts.more ? chunk_size : size_r;
        out_code_r <= FLT_NONE;
        out_last_r <= !sts.more;
      end
      default: begin
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_cmd        = out_cmd_r;
  assign out_rom_addr   = out_rom_r;
  assign out_ram_addr   = out_ram_r;
  assign out_length     = out_len_r;
  assign out_fault_code = out_code_r;
  assign out_last       = out_last_r;

endmodule
